// ===== hdl/sdes_pkg.sv =====
// Shared types, tables and permutation functions for the S-DES byte cipher.
`timescale 1ns / 1ps
package sdes_pkg;

  localparam int unsigned KEY_W  = 10;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CNT_W-1:0] MAX_PASSES   = 5'd16;
  localparam logic [CNT_W-1:0] PASS_DEFAULT = 5'd10;

  localparam logic REG_KEY  = 1'b0;
  localparam logic REG_PASS = 1'b1;

  localparam logic FUNC_ENC = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } sdes_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } sdes_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] npass;
  } sdes_stat_t;

  localparam logic [1:0] S0_TBL [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };

  localparam logic [1:0] S1_TBL [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  function automatic logic [9:0] p10(input logic [9:0] k);
    return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
  endfunction

  function automatic logic [7:0] p8(input logic [9:0] x);
    return {x[4], x[7], x[3], x[6], x[2], x[5], x[0], x[1]};
  endfunction

  function automatic logic [7:0] ip(input logic [7:0] b);
    return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
  endfunction

  function automatic logic [7:0] ip_inv(input logic [7:0] b);
    return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
  endfunction

  function automatic logic [7:0] ep(input logic [3:0] r);
    return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
  endfunction

  function automatic logic [3:0] p4(input logic [3:0] s);
    return {s[2], s[0], s[1], s[3]};
  endfunction

  function automatic logic [4:0] rotl1(input logic [4:0] x);
    return {x[3:0], x[4]};
  endfunction

  function automatic logic [4:0] rotl2(input logic [4:0] x);
    return {x[2:0], x[4:3]};
  endfunction

  function automatic logic [1:0] sbox0(input logic [3:0] n);
    return S0_TBL[{n[3], n[0], n[2:1]}];
  endfunction

  function automatic logic [1:0] sbox1(input logic [3:0] n);
    return S1_TBL[{n[3], n[0], n[2:1]}];
  endfunction

  function automatic logic [3:0] round_f(input logic [3:0] left, input logic [3:0] right,
                                         input logic [7:0] subkey);
    logic [7:0] x;
    x = ep(right) ^ subkey;
    return left ^ p4({sbox0(x[7:4]), sbox1(x[3:0])});
  endfunction

  function automatic logic [7:0] sdes_pass(input logic [7:0] b, input logic [7:0] ka,
                                           input logic [7:0] kb);
    logic [7:0] t;
    logic [3:0] l1;
    logic [3:0] l2;
    t  = ip(b);
    l1 = round_f(t[7:4], t[3:0], ka);
    l2 = round_f(t[3:0], l1, kb);
    return ip_inv({l2, l1});
  endfunction

endpackage

// ===== hdl/sdes_ctrl.sv =====
// Controller state machine that sequences the S-DES passes for one request.
`timescale 1ns / 1ps
module sdes_ctrl
  import sdes_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  sdes_stat_t stat,
  output sdes_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  sdes_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE, ST_DONE: begin
        out_valid = (state_r == ST_DONE);
        if (start) begin
          cmd.load = 1'b1;
          left_nxt = stat.npass;
          state_nxt = (stat.npass == '0) ? ST_DONE : ST_RUN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        left_nxt = left_r - 1'b1;
        if (left_r == 5'd1) begin
          state_nxt = ST_DONE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/sdes_dp.sv =====
// Datapath: configuration registers, subkey schedule and the one-pass S-DES unit.
`timescale 1ns / 1ps
module sdes_dp
  import sdes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [KEY_W-1:0]  cfg_wdata,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_func,
  input  sdes_cmd_t         cmd,
  output sdes_stat_t        stat,
  output logic [BYTE_W-1:0] out_result_byte
);

  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  count_r;
  logic [BYTE_W-1:0] byte_r;
  logic [7:0]        ka_r;
  logic [7:0]        kb_r;
  logic [9:0]        pk;
  logic [4:0]        lo1;
  logic [4:0]        ro1;
  logic [7:0]        k1;
  logic [7:0]        k2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      count_r <= PASS_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY:  key_r   <= cfg_wdata;
        REG_PASS: count_r <= cfg_wdata[CNT_W-1:0];
        default:  ;
      endcase
    end
  end

  assign pk  = p10(key_r);
  assign lo1 = rotl1(pk[9:5]);
  assign ro1 = rotl1(pk[4:0]);
  assign k1  = p8({lo1, ro1});
  assign k2  = p8({rotl2(lo1), rotl2(ro1)});

  assign stat.npass = (count_r > MAX_PASSES) ? MAX_PASSES : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
      ka_r   <= '0;
      kb_r   <= '0;
    end else if (cmd.load) begin
      byte_r <= in_data_byte;
      ka_r   <= (in_func == FUNC_ENC) ? k1 : k2;
      kb_r   <= (in_func == FUNC_ENC) ? k2 : k1;
    end else if (cmd.step) begin
      byte_r <= sdes_pass(byte_r, ka_r, kb_r);
    end
  end

  assign out_result_byte = byte_r;

endmodule

// ===== hdl/sdes_byte_cipher.sv =====
// Top level of the S-DES byte cipher: controller plus datapath.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. The byte then goes
// through the configured number of S-DES passes (pass_count, saturated at 16),
// one full pass per clock in a single pass unit, and the result appears on
// out_result_byte with out_valid high for exactly one cycle once the last pass
// is done (in the cycle after the request for a pass count of zero). The
// receiver cannot stall the result and must take it in that cycle. busy is low
// in the result cycle, so the next request may be accepted there. Registers
// must be written only while no request is in progress, which the block does
// not enforce: index 0 is the 10-bit key, index 1 the pass count.
module sdes_byte_cipher
  import sdes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_func,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_result_byte,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [KEY_W-1:0]  cfg_wdata
);

  sdes_cmd_t  cmd;
  sdes_stat_t stat;

  sdes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sdes_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_data_byte    (in_data_byte),
    .in_func         (in_func),
    .cmd             (cmd),
    .stat            (stat),
    .out_result_byte (out_result_byte)
  );

endmodule

// ===== hdl/sdes_checker.sv =====
// Port-level checker for the S-DES byte cipher and its bind to the top level.
`timescale 1ns / 1ps
module sdes_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither started nor finished");

  a_busy_progress: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (busy || out_valid))
    else $error("request dropped without a result");

  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind sdes_byte_cipher sdes_checker u_sdes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ===== tb/sv/sdes_byte_cipher_test.sv =====
// Self-checking testbench for the S-DES byte cipher with its own bit-level cipher predictor.
`timescale 1ns / 1ps
module sdes_byte_cipher_test
  import sdes_pkg::*;
();

  localparam logic FUNC_DEC = ~FUNC_ENC;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_PHASES = 12;
  localparam int RAND_ITEMS = 57;

  // Permutation tables, one 4-bit position per entry, first entry in the top nibble.
  localparam logic [39:0] TBL_P10 = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9, 4'd8,
                                     4'd6};
  localparam logic [39:0] TBL_P8 = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 8'd0};
  localparam logic [39:0] TBL_IP = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7, 8'd0};
  localparam logic [39:0] TBL_IPINV = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6, 8'd0};
  localparam logic [39:0] TBL_EP = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1, 8'd0};
  localparam logic [39:0] TBL_P4 = {4'd2, 4'd4, 4'd3, 4'd1, 24'd0};

  // S-box contents, row-major, first entry in the top two bits.
  localparam logic [31:0] BOX_A = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                   2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [31:0] BOX_B = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                   2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              func;
    int                gap;
    bit                drain;
  } cipher_req_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_func = FUNC_ENC;
  logic              out_valid;
  logic [BYTE_W-1:0] out_result_byte;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_KEY;
  logic [KEY_W-1:0]  cfg_wdata = '0;

  cipher_req_t       byte_requests[$];
  logic [BYTE_W-1:0] expected_bytes[$];
  cipher_req_t       next_req;
  logic [KEY_W-1:0]  model_key = '0;
  logic [CNT_W-1:0]  model_passes = PASS_DEFAULT;
  int                in_flight = 0;
  int                errors = 0;
  int                cycles = 0;
  bit                no_gaps = 1'b0;

  sdes_byte_cipher DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data_byte(in_data_byte),
    .in_func(in_func),
    .out_valid(out_valid),
    .out_result_byte(out_result_byte),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [9:0] permute_msb(input logic [9:0] val, input int src_w,
                                             input logic [39:0] tbl, input int out_w);
    logic [9:0] res;
    int pos;
    res = '0;
    for (int i = 0; i < out_w; i++) begin
      pos = int'(tbl[4*(9-i) +: 4]);
      res = {res[8:0], val[src_w-pos]};
    end
    return res;
  endfunction

  function automatic logic [4:0] rotate5(input logic [4:0] x, input int n);
    for (int i = 0; i < n; i++) begin
      x = {x[3:0], x[4]};
    end
    return x;
  endfunction

  function automatic logic [1:0] box_lookup(input logic [31:0] box, input logic [3:0] nib);
    int idx;
    idx = int'({nib[3], nib[0], nib[2:1]});
    return box[2*(15-idx) +: 2];
  endfunction

  function automatic logic [3:0] feistel(input logic [3:0] left, input logic [3:0] right,
                                         input logic [7:0] subkey);
    logic [9:0] wide;
    logic [7:0] mixed;
    logic [3:0] sub;
    wide = permute_msb({6'd0, right}, 4, TBL_EP, 8);
    mixed = wide[7:0] ^ subkey;
    sub = {box_lookup(BOX_A, mixed[7:4]), box_lookup(BOX_B, mixed[3:0])};
    wide = permute_msb({6'd0, sub}, 4, TBL_P4, 4);
    return left ^ wide[3:0];
  endfunction

  function automatic logic [7:0] cipher_pass(input logic [7:0] b, input logic [7:0] ka,
                                             input logic [7:0] kb);
    logic [9:0] wide;
    logic [3:0] l1;
    logic [3:0] l2;
    wide = permute_msb({2'd0, b}, 8, TBL_IP, 8);
    l1 = feistel(wide[7:4], wide[3:0], ka);
    l2 = feistel(wide[3:0], l1, kb);
    wide = permute_msb({2'd0, l2, l1}, 8, TBL_IPINV, 8);
    return wide[7:0];
  endfunction

  function automatic logic [BYTE_W-1:0] sdes_predict(input logic [BYTE_W-1:0] data,
                                                     input logic func);
    logic [9:0] perm;
    logic [9:0] wide;
    logic [4:0] lo;
    logic [4:0] ro;
    logic [7:0] k1;
    logic [7:0] k2;
    int passes;
    perm = permute_msb(model_key, 10, TBL_P10, 10);
    lo = rotate5(perm[9:5], 1);
    ro = rotate5(perm[4:0], 1);
    wide = permute_msb({lo, ro}, 10, TBL_P8, 8);
    k1 = wide[7:0];
    lo = rotate5(lo, 2);
    ro = rotate5(ro, 2);
    wide = permute_msb({lo, ro}, 10, TBL_P8, 8);
    k2 = wide[7:0];
    passes = (model_passes > MAX_PASSES) ? int'(MAX_PASSES) : int'(model_passes);
    for (int i = 0; i < passes; i++) begin
      data = (func == FUNC_DEC) ? cipher_pass(data, k2, k1) : cipher_pass(data, k1, k2);
    end
    return data;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_flight = 0;
    end else begin
      if (start && !busy) begin
        expected_bytes.push_back(sdes_predict(in_data_byte, in_func));
        in_flight++;
      end
      if (out_valid) begin
        in_flight--;
      end
      if (!start || !busy) begin
        if (byte_requests.size() == 0) begin
          start <= 1'b0;
        end else if (byte_requests[0].gap > 0) begin
          byte_requests[0].gap = byte_requests[0].gap - 1;
          start <= 1'b0;
        end else if (byte_requests[0].drain && in_flight != 0) begin
          start <= 1'b0;
        end else begin
          next_req = byte_requests.pop_front();
          start <= 1'b1;
          in_data_byte <= next_req.data;
          in_func <= next_req.func;
        end
      end
    end
  end

  always @(negedge clk) begin
    logic [BYTE_W-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_bytes.size() == 0) begin
        if (errors < 10) $display("Unexpected result byte %02h", out_result_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_result_byte !== want) begin
          if (errors < 10) begin
            $display("Mismatch on result_byte: expected %02h, actual %02h", want,
                     out_result_byte);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic [BYTE_W-1:0] data, input logic func,
                               input bit drain);
    cipher_req_t req;
    req.data = data;
    req.func = func;
    req.gap = no_gaps ? 0 : $urandom_range(0, 4);
    req.drain = drain;
    byte_requests.push_back(req);
  endtask

  task automatic wait_idle();
    while (byte_requests.size() != 0 || start || in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [KEY_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY) model_key = val;
    else model_passes = val[CNT_W-1:0];
  endtask

  task automatic set_config(input logic [KEY_W-1:0] key, input logic [CNT_W-1:0] passes);
    logic [KEY_W-CNT_W-1:0] junk;
    wait_idle();
    repeat (20) @(negedge clk);
    junk = (KEY_W-CNT_W)'($urandom_range(0, 31));
    write_reg(REG_KEY, key);
    write_reg(REG_PASS, {junk, passes});
    @(negedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] last_data;
    logic              last_func;
    logic [BYTE_W-1:0] data;
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  passes;
    logic [CNT_W-1:0]  edge_counts[5];
    edge_counts = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration first, then zero, one, full, saturated and largest pass counts.
    queue_request(8'h00, FUNC_ENC, 1'b0);
    queue_request(8'h00, FUNC_DEC, 1'b0);
    queue_request(8'hFF, FUNC_ENC, 1'b0);
    queue_request(8'hFF, FUNC_DEC, 1'b0);
    queue_request(8'h80, FUNC_ENC, 1'b0);
    queue_request(8'h01, FUNC_DEC, 1'b1);
    queue_request(8'hAA, FUNC_ENC, 1'b0);
    queue_request(8'h55, FUNC_DEC, 1'b0);
    set_config(10'h3FF, 5'd0);
    queue_request(8'hA5, FUNC_ENC, 1'b0);
    queue_request(8'h5A, FUNC_DEC, 1'b0);
    set_config(10'h3FF, 5'd1);
    queue_request(8'h00, FUNC_ENC, 1'b0);
    queue_request(8'hFF, FUNC_DEC, 1'b0);
    set_config(10'h2AA, 5'd16);
    queue_request(8'h3C, FUNC_ENC, 1'b0);
    queue_request(8'hC3, FUNC_DEC, 1'b0);
    set_config(10'h155, 5'd17);
    queue_request(8'h7E, FUNC_ENC, 1'b0);
    queue_request(8'h81, FUNC_DEC, 1'b1);
    set_config(10'h000, 5'd31);
    queue_request(8'h12, FUNC_ENC, 1'b0);
    queue_request(8'hED, FUNC_DEC, 1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: key = '0;
        1: key = '1;
        default: key = KEY_W'($urandom_range(0, 1023));
      endcase
      if ($urandom_range(0, 2) == 0) passes = edge_counts[$urandom_range(0, 4)];
      else passes = CNT_W'($urandom_range(1, 16));
      set_config(key, passes);
      no_gaps = ($urandom_range(0, 3) == 0);
      last_data = BYTE_W'($urandom_range(0, 255));
      last_func = 1'($urandom_range(0, 1));
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          data = sdes_predict(last_data, last_func);
          func = ~last_func;
        end else begin
          data = BYTE_W'($urandom_range(0, 255));
          func = 1'($urandom_range(0, 1));
        end
        queue_request(data, func, $urandom_range(0, 39) == 0);
        last_data = data;
        last_func = func;
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_bytes.size() != 0) begin
      if (errors < 10) $display("%0d expected result bytes never arrived", expected_bytes.size());
      errors += expected_bytes.size();
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sdes_pkg.sv
hdl/sdes_ctrl.sv
hdl/sdes_dp.sv
hdl/sdes_byte_cipher.sv
hdl/sdes_checker.sv
tb/sv/sdes_byte_cipher_test.sv
